### hdl/tfs_pkg.sv
package tfs_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int RANK_W    = 8;
	localparam int HELD_W    = 9;
	// ranks reachable by a read transaction
	localparam int READ_SPAN = 2 ** RANK_W;

	localparam logic ACT_OFFER = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	typedef struct packed {
		logic [31:0] dst_addr;
		logic [7:0]  protocol;
		logic [31:0] pkt_count;
		logic [31:0] byte_count;
	} rec_t;

	// hand-off from one list cell to its right neighbor
	typedef struct packed {
		logic take;
		rec_t rec;
	} link_t;

	// read token walking the row
	typedef struct packed {
		logic              vld;
		logic [RANK_W-1:0] cnt;
	} rd_tok_t;

	typedef struct packed {
		logic              valid_res;
		rec_t              rec;
		logic [HELD_W-1:0] held;
	} res_t;

endpackage

### hdl/tfs_if.sv
interface tfs_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic        first;
	logic [31:0] dst_addr;
	logic [7:0]  protocol;
	logic [31:0] pkt_count;
	logic [31:0] byte_count;
	logic [7:0]  rank;

	modport source (
		output valid, action, first, dst_addr, protocol, pkt_count, byte_count, rank,
		input  ready
	);
	modport sink (
		input  valid, action, first, dst_addr, protocol, pkt_count, byte_count, rank,
		output ready
	);
endinterface

interface tfs_rsp_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [31:0] out_dst_addr;
	logic [7:0]  out_protocol;
	logic [31:0] out_pkt_count;
	logic [31:0] out_byte_count;
	logic [8:0]  held;

	modport source (
		output valid, valid_res, out_dst_addr, out_protocol, out_pkt_count,
			out_byte_count, held,
		input  ready
	);
	modport sink (
		input  valid, valid_res, out_dst_addr, out_protocol, out_pkt_count,
			out_byte_count, held,
		output ready
	);
endinterface

### hdl/tfs_cell.sv
module tfs_cell #(
	parameter int DEPTH = tfs_pkg::DEPTH_DEF,
	parameter int IDX = 0,
	localparam int HW = $clog2(DEPTH + 1)
) (
	input  logic            clk,
	input  logic            upd,
	input  tfs_pkg::rec_t   new_rec,
	input  logic [HW-1:0]   fill,
	input  tfs_pkg::link_t  left,
	output tfs_pkg::link_t  right,
	output tfs_pkg::rec_t   rec
);
	import tfs_pkg::*;

	localparam logic [HW-1:0] IDX_V = HW'(IDX);

	rec_t rec_q;
	logic take;

	// empty slot, or strictly smaller count than the offered record
	assign take = (fill <= IDX_V) || (new_rec.pkt_count > rec_q.pkt_count);

	always_ff @(posedge clk) begin
		if (upd) begin
			if (left.take) begin
				rec_q <= left.rec;
			end else if (take) begin
				rec_q <= new_rec;
			end
		end
	end

	assign right = '{take: take, rec: rec_q};
	assign rec   = rec_q;

endmodule

### hdl/tfs_rd_cell.sv
module tfs_rd_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  tfs_pkg::rd_tok_t tok_in,
	input  tfs_pkg::rec_t    rec_in,
	input  tfs_pkg::rec_t    own,
	output tfs_pkg::rd_tok_t tok_out,
	output tfs_pkg::rec_t    rec_out
);
	import tfs_pkg::*;

	rd_tok_t tok_q;
	rec_t    rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.vld <= tok_in.vld;
			tok_q.cnt <= tok_in.cnt - RANK_W'(1);
		end
	end

	// countdown hits zero at the requested rank
	always_ff @(posedge clk) begin
		if (tok_in.vld && (tok_in.cnt == '0)) begin
			rec_q <= own;
		end else begin
			rec_q <= rec_in;
		end
	end

	assign tok_out = tok_q;
	assign rec_out = rec_q;

endmodule

### hdl/top_flow_selector_unit.sv
// Sorted top-DEPTH list of flow records held in a row of cells, largest packet
// count at rank 0. An offer transaction is broadcast to every cell; each cell
// compares it with its own entry and either keeps its entry, takes the offered
// record or takes its left neighbor's entry, so an offer updates the whole row at
// once, and another transaction can follow it while the output queue has room. A
// read transaction whose rank lies beyond the fill level is answered directly,
// without a walk. A read within the list sends a token down the row of read
// cells, one cell per cycle; no transaction is taken while it walks. Results
// go through a two-entry output queue, so input keeps flowing while a result
// waits. held reports the fill level modulo 512.
module top_flow_selector_unit #(
	parameter int DEPTH = tfs_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tfs_req_if.sink   req,
	tfs_rsp_if.source rsp
);
	import tfs_pkg::*;

	localparam int HW   = $clog2(DEPTH + 1);
	localparam int CW   = (HW > RANK_W) ? HW : RANK_W;
	localparam int RD_N = (DEPTH < READ_SPAN) ? DEPTH : READ_SPAN;
	localparam logic [HW-1:0] FULL = HW'(DEPTH);

	logic [HW-1:0] held_q;
	logic          busy_q;
	rd_tok_t       tok0_q;

	res_t          res_mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	logic          acc;
	logic          upd;
	logic          rd_acc;
	logic          rd_hit;
	logic          rd_done;
	logic          kept;
	logic [HW-1:0] fill;
	logic [HW-1:0] held_nxt;
	rec_t          new_rec;
	logic          push;
	logic          pop;
	res_t          push_res;

	link_t         lnk  [DEPTH+1];
	rec_t          ent  [DEPTH];
	rd_tok_t       rtok [RD_N+1];
	rec_t          rrec [RD_N+1];

	assign req.ready = !busy_q && (cnt_q != 2'd2);
	assign acc       = req.valid && req.ready;
	assign upd       = acc && (req.action == ACT_OFFER);
	assign rd_acc    = acc && (req.action == ACT_READ);
	assign rd_hit    = CW'(req.rank) < CW'(held_q);

	assign new_rec = '{dst_addr: req.dst_addr, protocol: req.protocol,
		pkt_count: req.pkt_count, byte_count: req.byte_count};
	assign fill = req.first ? '0 : held_q;

	// list row
	assign lnk[0] = '{take: 1'b0, rec: '0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		tfs_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk     (clk),
			.upd     (upd),
			.new_rec (new_rec),
			.fill    (fill),
			.left    (lnk[i]),
			.right   (lnk[i+1]),
			.rec     (ent[i])
		);
	end

	// every cell at or after the insert point takes, so the last one tells
	assign kept     = lnk[DEPTH].take;
	assign held_nxt = (kept && (fill != FULL)) ? fill + HW'(1) : fill;

	// read row
	assign rtok[0] = tok0_q;
	assign rrec[0] = '0;

	for (genvar j = 0; j < RD_N; j++) begin : g_rd
		tfs_rd_cell u_rd_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (rtok[j]),
			.rec_in  (rrec[j]),
			.own     (ent[j]),
			.tok_out (rtok[j+1]),
			.rec_out (rrec[j+1])
		);
	end

	assign rd_done = rtok[RD_N].vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			busy_q <= 1'b0;
			tok0_q <= '0;
		end else begin
			if (upd) begin
				held_q <= held_nxt;
			end
			tok0_q.vld <= rd_acc && rd_hit;
			if (rd_acc && rd_hit) begin
				tok0_q.cnt <= req.rank;
				busy_q     <= 1'b1;
			end else if (rd_done) begin
				busy_q     <= 1'b0;
			end
		end
	end

	// result selection
	always_comb begin
		push_res = '0;
		push     = 1'b0;
		if (rd_done) begin
			push               = 1'b1;
			push_res.valid_res = 1'b1;
			push_res.rec       = rrec[RD_N];
			push_res.held      = HELD_W'(held_q);
		end else if (upd) begin
			push               = 1'b1;
			push_res.valid_res = kept;
			push_res.held      = HELD_W'(held_nxt);
		end else if (rd_acc && !rd_hit) begin
			push               = 1'b1;
			push_res.held      = HELD_W'(held_q);
		end
	end

	// two-entry output queue
	assign pop = rsp.valid && rsp.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			res_mem_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign rsp.valid          = (cnt_q != 2'd0);
	assign rsp.valid_res      = res_mem_q[rd_ptr_q].valid_res;
	assign rsp.out_dst_addr   = res_mem_q[rd_ptr_q].rec.dst_addr;
	assign rsp.out_protocol   = res_mem_q[rd_ptr_q].rec.protocol;
	assign rsp.out_pkt_count  = res_mem_q[rd_ptr_q].rec.pkt_count;
	assign rsp.out_byte_count = res_mem_q[rd_ptr_q].rec.byte_count;
	assign rsp.held           = res_mem_q[rd_ptr_q].held;

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= FULL)
		else $error("fill level above list depth");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_done |-> busy_q)
		else $error("read token finished with no read pending");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && (cnt_q == 2'd2)))
		else $error("output queue overflow");

	a_first_one: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && req.first) |=> (held_q == HW'(1)))
		else $error("offer with first flag did not leave one entry");

	a_not_full_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && (fill != FULL)) |-> kept)
		else $error("offer dropped while list not full");
`endif

endmodule

### test/top_flow_selector_unit_tb.sv
`timescale 1ns / 100ps

module top_flow_selector_unit_tb;

	import tfs_pkg::*;

	localparam int LIST_DEPTH   = DEPTH_DEF;
	localparam int N_RANDOM     = 1750;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = LIST_DEPTH + 40;
	localparam int N_DIR        = 21;

	typedef struct packed {
		logic              action;
		logic              first;
		rec_t              rec;
		logic [RANK_W-1:0] rank;
	} flow_req_t;

	typedef struct {
		logic              action;
		logic              first;
		logic [31:0]       dst;
		logic [7:0]        proto;
		logic [31:0]       pkts;
		logic [31:0]       bytes;
		logic [RANK_W-1:0] rank;
		bit                typed;
		logic              w_ok;
		logic [31:0]       w_dst;
		logic [7:0]        w_proto;
		logic [31:0]       w_pkts;
		logic [31:0]       w_bytes;
		logic [HELD_W-1:0] w_held;
	} dir_row_t;

	logic clk;
	logic arst_n;

	tfs_req_if req();
	tfs_rsp_if rsp();

	top_flow_selector_unit #(.DEPTH(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// predicted ranked list and the results still owed by the block
	rec_t        ranked [LIST_DEPTH];
	int unsigned fill;
	res_t        expected_q [$];

	bit          idle_en;
	bit          hold_go;
	bit          hold_rsp;
	int unsigned n_bad;
	int unsigned n_sent;
	int unsigned n_offer;
	int unsigned n_read;
	int unsigned n_drop;
	int unsigned n_miss;
	int unsigned peak_fill;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

	function automatic res_t predict_flow(flow_req_t it);
		res_t        r;
		int unsigned pos;
		int unsigned last;
		int unsigned i;
		r = '0;
		if (it.action == ACT_READ) begin
			n_read++;
			if (it.rank < fill) begin
				r.valid_res = 1'b1;
				r.rec       = ranked[it.rank];
			end else begin
				n_miss++;
			end
		end else begin
			n_offer++;
			if (it.first)
				fill = 0;
			// equal counts keep the older entry ahead
			pos = 0;
			while (pos < fill && ranked[pos].pkt_count >= it.rec.pkt_count)
				pos++;
			if (pos < LIST_DEPTH) begin
				last = (fill < LIST_DEPTH) ? fill : LIST_DEPTH - 1;
				for (i = last; i > pos; i--)
					ranked[i] = ranked[i-1];
				ranked[pos] = it.rec;
				if (fill < LIST_DEPTH)
					fill++;
				r.valid_res = 1'b1;
			end else begin
				n_drop++;
			end
			if (fill > peak_fill)
				peak_fill = fill;
		end
		r.held = HELD_W'(fill);
		return r;
	endfunction

	function automatic logic [31:0] pick_count(bit narrow);
		if (narrow)
			return $urandom_range(15);
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(15);
			default: return $urandom();
		endcase
	endfunction

	function automatic flow_req_t rand_offer(bit first, bit narrow);
		flow_req_t r;
		r.action         = ACT_OFFER;
		r.first          = first;
		r.rec.dst_addr   = $urandom();
		r.rec.protocol   = 8'($urandom());
		r.rec.pkt_count  = pick_count(narrow);
		r.rec.byte_count = $urandom();
		r.rank           = RANK_W'($urandom());
		return r;
	endfunction

	function automatic flow_req_t rand_read();
		flow_req_t r;
		r.action         = ACT_READ;
		r.first          = 1'($urandom_range(1));
		r.rec.dst_addr   = $urandom();
		r.rec.protocol   = 8'($urandom());
		r.rec.pkt_count  = $urandom();
		r.rec.byte_count = $urandom();
		// mostly ranks inside the list, the rest anywhere
		if (fill > 0 && $urandom_range(9) < 8)
			r.rank = RANK_W'($urandom_range(fill - 1));
		else
			r.rank = RANK_W'($urandom());
		return r;
	endfunction

	task automatic note_mismatch(string what, res_t want, res_t got);
		n_bad++;
		if (n_bad <= 10) begin
			$display("%0t %s: expected ok=%0b dst=%h proto=%h pkts=%h bytes=%h held=%0d",
				$realtime, what, want.valid_res, want.rec.dst_addr, want.rec.protocol,
				want.rec.pkt_count, want.rec.byte_count, want.held);
			$display("%0t %s: actual   ok=%0b dst=%h proto=%h pkts=%h bytes=%h held=%0d",
				$realtime, what, got.valid_res, got.rec.dst_addr, got.rec.protocol,
				got.rec.pkt_count, got.rec.byte_count, got.held);
		end
	endtask

	task automatic send_req(flow_req_t it, bit typed, res_t typed_res);
		res_t calc;
		while (idle_en && $urandom_range(99) < 9) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid      = 1'b1;
		req.action     = it.action;
		req.first      = it.first;
		req.dst_addr   = it.rec.dst_addr;
		req.protocol   = it.rec.protocol;
		req.pkt_count  = it.rec.pkt_count;
		req.byte_count = it.rec.byte_count;
		req.rank       = it.rank;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		calc = predict_flow(it);
		expected_q.push_back(typed ? typed_res : calc);
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	// a fresh list: a first-flagged offer, then offers, now and then first-flagged, mixed with reads
	task automatic run_burst(int n, int read_pct, bit narrow);
		res_t none = '0;
		send_req(rand_offer(1'b1, narrow), 1'b0, none);
		n_sent++;
		repeat (n) begin
			if ($urandom_range(99) < read_pct)
				send_req(rand_read(), 1'b0, none);
			else
				send_req(rand_offer($urandom_range(99) < 2, narrow), 1'b0, none);
			n_sent++;
		end
	endtask

	task automatic pause_until_drained();
		wait (expected_q.size() == 0);
		repeat ($urandom_range(20, 3)) @(negedge clk);
	endtask

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready = arst_n && !hold_rsp && !(idle_en && $urandom_range(99) < 9);
		end
	end

	// long receiver hold-off so the output queue fills and the input stalls
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_rsp = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rsp = 1'b0;
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			got.valid_res      = rsp.valid_res;
			got.rec.dst_addr   = rsp.out_dst_addr;
			got.rec.protocol   = rsp.out_protocol;
			got.rec.pkt_count  = rsp.out_pkt_count;
			got.rec.byte_count = rsp.out_byte_count;
			got.held           = rsp.held;
			if (expected_q.size() == 0) begin
				note_mismatch("unexpected transaction", '0, got);
			end else begin
				want = expected_q.pop_front();
				if (got.valid_res !== want.valid_res || got.rec.dst_addr !== want.rec.dst_addr
						|| got.rec.protocol !== want.rec.protocol
						|| got.rec.pkt_count !== want.rec.pkt_count
						|| got.rec.byte_count !== want.rec.byte_count
						|| got.held !== want.held)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	initial begin
		dir_row_t  dir_tab [N_DIR];
		flow_req_t it;
		res_t      want;

		req.valid      = 1'b0;
		req.action     = ACT_OFFER;
		req.first      = 1'b0;
		req.dst_addr   = '0;
		req.protocol   = '0;
		req.pkt_count  = '0;
		req.byte_count = '0;
		req.rank       = '0;
		fill           = 0;
		arst_n         = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// act first dst proto pkts bytes rank | typed ok dst proto pkts bytes held
		dir_tab = '{
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd0,
				1'b1, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd0},
			'{ACT_READ,  1'b1, '1, '1, '1, '1, 8'd255,
				1'b1, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd0},
			'{ACT_OFFER, 1'b1, '1, '1, '1, '1, 8'd255,
				1'b1, 1'b1, 32'h0, 8'h00, 32'h0, 32'h0, 9'd1},
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd0,
				1'b1, 1'b1, '1, '1, '1, '1, 9'd1},
			'{ACT_OFFER, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd0,
				1'b1, 1'b1, 32'h0, 8'h00, 32'h0, 32'h0, 9'd2},
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd1,
				1'b1, 1'b1, 32'h0, 8'h00, 32'h0, 32'h0, 9'd2},
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd2,
				1'b1, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd2},
			// tie with the head entry, goes behind it
			'{ACT_OFFER, 1'b0, 32'h1111_1111, 8'h11, '1, 32'h2222_2222, 8'd0,
				1'b0, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd0},
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd0,
				1'b0, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd0},
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd1,
				1'b0, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd0},
			// tie with the tail entry
			'{ACT_OFFER, 1'b0, 32'h3333_3333, 8'h06, 32'h0, 32'h4444_4444, 8'd7,
				1'b0, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd0},
			'{ACT_OFFER, 1'b0, 32'h0A00_0001, 8'h11, 32'h8000_0000, 32'hDEAD_BEEF, 8'd0,
				1'b0, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd0},
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd2,
				1'b0, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd0},
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd3,
				1'b0, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd0},
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd4,
				1'b0, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd0},
			'{ACT_OFFER, 1'b1, 32'hC0A8_0001, 8'h06, 32'd5, 32'h0000_05DC, 8'd0,
				1'b1, 1'b1, 32'h0, 8'h00, 32'h0, 32'h0, 9'd1},
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd1,
				1'b1, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd1},
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd0,
				1'b0, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd0},
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd255,
				1'b1, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd1},
			'{ACT_OFFER, 1'b1, 32'h0, 8'h00, 32'h0, 32'h0, 8'd0,
				1'b1, 1'b1, 32'h0, 8'h00, 32'h0, 32'h0, 9'd1},
			'{ACT_READ,  1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 8'd0,
				1'b0, 1'b0, 32'h0, 8'h00, 32'h0, 32'h0, 9'd0}
		};

		idle_en = 1'b1;
		foreach (dir_tab[k]) begin
			it.action          = dir_tab[k].action;
			it.first           = dir_tab[k].first;
			it.rec.dst_addr    = dir_tab[k].dst;
			it.rec.protocol    = dir_tab[k].proto;
			it.rec.pkt_count   = dir_tab[k].pkts;
			it.rec.byte_count  = dir_tab[k].bytes;
			it.rank            = dir_tab[k].rank;
			want.valid_res      = dir_tab[k].w_ok;
			want.rec.dst_addr   = dir_tab[k].w_dst;
			want.rec.protocol   = dir_tab[k].w_proto;
			want.rec.pkt_count  = dir_tab[k].w_pkts;
			want.rec.byte_count = dir_tab[k].w_bytes;
			want.held           = dir_tab[k].w_held;
			send_req(it, dir_tab[k].typed, want);
		end

		// no idling here; receiver held off while offers keep coming
		idle_en = 1'b0;
		hold_go = 1'b1;
		run_burst(300, 5, 1'b1);
		idle_en = 1'b1;
		pause_until_drained();
		run_burst(300, 10, 1'b0);

		while (n_sent < N_RANDOM) begin
			if ($urandom_range(9) == 0)
				run_burst($urandom_range(320, 260), 10, 1'($urandom_range(1)));
			else
				run_burst($urandom_range(40, 1), 30, $urandom_range(3) == 0);
			if ($urandom_range(3) == 0)
				pause_until_drained();
		end

		req.valid = 1'b0;
		wait (expected_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		n_bad += expected_q.size();

		$display("covered %0d offers (%0d dropped on a full list) and %0d reads",
			n_offer, n_drop, n_read);
		$display("%0d reads past the fill level, peak fill %0d of %0d",
			n_miss, peak_fill, LIST_DEPTH);
		if (n_bad == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
